### rtl/pim_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pim_pkg;

  localparam int DIM_W      = 12;
  localparam int COEF_W     = 32;
  localparam int NUM_COEF   = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int COEF_IDX_W = $clog2(NUM_COEF);

  localparam int DEF_SRC_WIDTH  = 2048;
  localparam int DEF_SRC_HEIGHT = 2048;

  localparam int MUL_W   = COEF_W + DIM_W + 1;
  localparam int SUM_W   = MUL_W + 2;
  localparam int FRAC_SH = 14;
  localparam int QUO_W   = DIM_W;
  localparam int REM_W   = SUM_W + FRAC_SH;

  localparam logic [COEF_IDX_W-1:0] REG_XX = COEF_IDX_W'(0);
  localparam logic [COEF_IDX_W-1:0] REG_XY = COEF_IDX_W'(1);
  localparam logic [COEF_IDX_W-1:0] REG_XC = COEF_IDX_W'(2);
  localparam logic [COEF_IDX_W-1:0] REG_YX = COEF_IDX_W'(3);
  localparam logic [COEF_IDX_W-1:0] REG_YY = COEF_IDX_W'(4);
  localparam logic [COEF_IDX_W-1:0] REG_YC = COEF_IDX_W'(5);
  localparam logic [COEF_IDX_W-1:0] REG_WX = COEF_IDX_W'(6);
  localparam logic [COEF_IDX_W-1:0] REG_WY = COEF_IDX_W'(7);

  localparam logic [COEF_W-1:0]       ONE_Q16 = COEF_W'(65536);
  localparam logic signed [SUM_W-1:0] ONE_Q30 = SUM_W'(64'sd1073741824);

  typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_arr_t;

  typedef struct packed {
    logic [REM_W-1:0] rem_x;
    logic [REM_W-1:0] rem_y;
    logic [SUM_W-1:0] d;
    logic [QUO_W-1:0] q_x;
    logic [QUO_W-1:0] q_y;
    logic             neg_x;
    logic             neg_y;
    logic             ovf_x;
    logic             ovf_y;
    logic             wzero;
  } div_t;

endpackage

`default_nettype wire

### rtl/pim_dst_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pim_dst_if;
  import pim_pkg::*;

  logic             valid;
  logic             ready;
  logic [DIM_W-1:0] dst_x;
  logic [DIM_W-1:0] dst_y;

  modport source (output valid, output dst_x, output dst_y, input ready);
  modport sink (input valid, input dst_x, input dst_y, output ready);
endinterface

`default_nettype wire

### rtl/pim_src_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pim_src_if;
  import pim_pkg::*;

  logic             valid;
  logic             ready;
  logic [DIM_W-1:0] src_x;
  logic [DIM_W-1:0] src_y;
  logic             inside_res;

  modport source (output valid, output src_x, output src_y, output inside_res, input ready);
  modport sink (input valid, input src_x, input src_y, input inside_res, output ready);
endinterface

`default_nettype wire

### rtl/pim_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pim_cfg_if;
  import pim_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEF_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/pim_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module pim_cfg (
  input  wire               clk,
  input  wire               rst,
  pim_cfg_if.sink           cfg,
  output pim_pkg::coef_arr_t coef
);
  import pim_pkg::*;

  coef_arr_t coef_rst;

  assign cfg.ready = 1'b1;

  always_comb begin
    coef_rst         = '0;
    coef_rst[REG_XX] = ONE_Q16;
    coef_rst[REG_YY] = ONE_Q16;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= coef_rst;
    end else if (cfg.valid && (cfg.index < CFG_IDX_W'(NUM_COEF))) begin
      coef[cfg.index[COEF_IDX_W-1:0]] <= cfg.data;
    end
  end

endmodule

`default_nettype wire

### rtl/pim_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pim_front (
  input  wire                clk,
  input  wire                rst,
  pim_dst_if.sink            dst,
  input  pim_pkg::coef_arr_t coef,
  output logic               dout_valid,
  input  wire                dout_ready,
  output pim_pkg::div_t      dout
);
  import pim_pkg::*;

  logic v1, v2, v3;
  logic r1, r2, r3, r4;

  logic signed [DIM_W:0]   xs, ys;
  logic signed [MUL_W-1:0] p_xx, p_xy, p_yx, p_yy, p_wx, p_wy;
  logic signed [SUM_W-1:0] nx, ny, w;
  logic [SUM_W-1:0]        mag_x, mag_y, mag_w;
  logic                    neg_x, neg_y, wzero;
  logic [REM_W-1:0]        num_x, num_y, den_top;

  assign r4        = !dout_valid || dout_ready;
  assign r3        = !v3 || r4;
  assign r2        = !v2 || r3;
  assign r1        = !v1 || r2;
  assign dst.ready = r1;

  assign xs = signed'({1'b0, dst.dst_x});
  assign ys = signed'({1'b0, dst.dst_y});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      dout_valid <= 1'b0;
    end else begin
      if (r1) v1 <= dst.valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) dout_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      p_xx <= signed'(coef[REG_XX]) * xs;
      p_xy <= signed'(coef[REG_XY]) * ys;
      p_yx <= signed'(coef[REG_YX]) * xs;
      p_yy <= signed'(coef[REG_YY]) * ys;
      p_wx <= signed'(coef[REG_WX]) * xs;
      p_wy <= signed'(coef[REG_WY]) * ys;
    end
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      nx <= SUM_W'(p_xx) + SUM_W'(p_xy) + SUM_W'(signed'(coef[REG_XC]));
      ny <= SUM_W'(p_yx) + SUM_W'(p_yy) + SUM_W'(signed'(coef[REG_YC]));
      w  <= SUM_W'(p_wx) + SUM_W'(p_wy) + ONE_Q30;
    end
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      mag_x <= nx[SUM_W-1] ? (~nx + SUM_W'(1)) : nx;
      mag_y <= ny[SUM_W-1] ? (~ny + SUM_W'(1)) : ny;
      mag_w <= w[SUM_W-1] ? (~w + SUM_W'(1)) : w;
      neg_x <= nx[SUM_W-1] ^ w[SUM_W-1];
      neg_y <= ny[SUM_W-1] ^ w[SUM_W-1];
      wzero <= (w == '0);
    end
  end

  assign num_x   = {mag_x, FRAC_SH'(0)};
  assign num_y   = {mag_y, FRAC_SH'(0)};
  assign den_top = REM_W'({mag_w, QUO_W'(0)});

  always_ff @(posedge clk) begin
    if (r4) begin
      dout.rem_x <= num_x;
      dout.rem_y <= num_y;
      dout.d     <= mag_w;
      dout.q_x   <= '0;
      dout.q_y   <= '0;
      dout.neg_x <= neg_x;
      dout.neg_y <= neg_y;
      dout.ovf_x <= (num_x >= den_top);
      dout.ovf_y <= (num_y >= den_top);
      dout.wzero <= wzero;
    end
  end

endmodule

`default_nettype wire

### rtl/pim_div.sv
`timescale 1ns / 1ps
`default_nettype none

module pim_div #(
  parameter int SRC_WIDTH  = pim_pkg::DEF_SRC_WIDTH,
  parameter int SRC_HEIGHT = pim_pkg::DEF_SRC_HEIGHT
) (
  input  wire           clk,
  input  wire           rst,
  input  wire           din_valid,
  output logic          din_ready,
  input  pim_pkg::div_t din,
  pim_src_if.source     src
);
  import pim_pkg::*;

  localparam logic [QUO_W:0] XLIM = (QUO_W + 1)'(SRC_WIDTH);
  localparam logic [QUO_W:0] YLIM = (QUO_W + 1)'(SRC_HEIGHT);

  div_t stg [QUO_W];
  logic vld [QUO_W];
  logic rdy [QUO_W];
  logic out_rdy;
  div_t fin;
  logic ok_x, ok_y, ok;

  assign out_rdy   = !src.valid || src.ready;
  assign din_ready = rdy[0];

  for (genvar s = 0; s < QUO_W; s++) begin : g_step
    localparam int BIT = QUO_W - 1 - s;
    div_t             cur;
    div_t             nxt;
    logic             cur_vld;
    logic             nxt_rdy;
    logic [REM_W-1:0] dsh;
    logic [REM_W-1:0] dif_x, dif_y;
    logic             brw_x, brw_y;

    if (s == 0) begin : g_first
      assign cur     = din;
      assign cur_vld = din_valid;
    end else begin : g_rest
      assign cur     = stg[s-1];
      assign cur_vld = vld[s-1];
    end

    if (s == QUO_W - 1) begin : g_last
      assign nxt_rdy = out_rdy;
    end else begin : g_mid
      assign nxt_rdy = rdy[s+1];
    end

    assign rdy[s] = !vld[s] || nxt_rdy;

    always_comb begin
      dsh            = REM_W'(cur.d) << BIT;
      {brw_x, dif_x} = {1'b0, cur.rem_x} - {1'b0, dsh};
      {brw_y, dif_y} = {1'b0, cur.rem_y} - {1'b0, dsh};
      nxt            = cur;
      if (!brw_x) begin
        nxt.rem_x    = dif_x;
        nxt.q_x[BIT] = 1'b1;
      end
      if (!brw_y) begin
        nxt.rem_y    = dif_y;
        nxt.q_y[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld[s] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) stg[s] <= nxt;
    end
  end

  assign fin  = stg[QUO_W-1];
  assign ok_x = !fin.ovf_x && ((fin.q_x == '0) || !fin.neg_x) && ({1'b0, fin.q_x} < XLIM);
  assign ok_y = !fin.ovf_y && ((fin.q_y == '0) || !fin.neg_y) && ({1'b0, fin.q_y} < YLIM);
  assign ok   = !fin.wzero && ok_x && ok_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      src.valid <= 1'b0;
    end else if (out_rdy) begin
      src.valid <= vld[QUO_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      src.src_x      <= ok ? fin.q_x : '0;
      src.src_y      <= ok ? fin.q_y : '0;
      src.inside_res <= ok;
    end
  end

endmodule

`default_nettype wire

### rtl/perspective_inverse_mapper.sv
// Channel  Dir  Payload                      Beat taken when
// dst      in   dst_x, dst_y                 dst.valid && dst.ready
// src      out  src_x, src_y, inside_res     src.valid && src.ready
// cfg      in   index, data                  cfg.valid && cfg.ready
//
// One pixel enters per clock while src.ready does not stall the pipeline.
// Four front stages form the products, sums and magnitudes, and the quotient
// comes from a restoring divider of twelve stages, one quotient bit per stage.
// Reset clears every valid bit and loads the identity coefficients.
// A full stage holds its beat while the next stage is full and held; empty stages fill.
`timescale 1ns / 1ps
`default_nettype none

module perspective_inverse_mapper #(
  parameter int SRC_WIDTH  = pim_pkg::DEF_SRC_WIDTH,
  parameter int SRC_HEIGHT = pim_pkg::DEF_SRC_HEIGHT
) (
  input  wire       clk,
  input  wire       rst,
  pim_dst_if.sink   dst,
  pim_src_if.source src,
  pim_cfg_if.sink   cfg
);
  import pim_pkg::*;

  coef_arr_t coef;
  logic      mid_valid;
  logic      mid_ready;
  div_t      mid;

  pim_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .coef (coef)
  );

  pim_front u_front (
    .clk        (clk),
    .rst        (rst),
    .dst        (dst),
    .coef       (coef),
    .dout_valid (mid_valid),
    .dout_ready (mid_ready),
    .dout       (mid)
  );

  pim_div #(
    .SRC_WIDTH  (SRC_WIDTH),
    .SRC_HEIGHT (SRC_HEIGHT)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .din_valid (mid_valid),
    .din_ready (mid_ready),
    .din       (mid),
    .src       (src)
  );

  a_clear_when_outside : assert property (@(posedge clk) disable iff (rst)
    src.valid && !src.inside_res |-> (src.src_x == '0) && (src.src_y == '0))
    else $error("outside result carries a nonzero coordinate");

  a_inside_in_bounds : assert property (@(posedge clk) disable iff (rst)
    src.valid && src.inside_res |->
      ({1'b0, src.src_x} < (DIM_W + 1)'(SRC_WIDTH)) &&
      ({1'b0, src.src_y} < (DIM_W + 1)'(SRC_HEIGHT)))
    else $error("inside result lies past the source bounds");

  a_mid_hold : assert property (@(posedge clk) disable iff (rst)
    mid_valid && !mid_ready |=> mid_valid && $stable(mid))
    else $error("front stage lost a stalled beat");

  a_reset_empty : assert property (@(posedge clk)
    $past(rst) |-> !src.valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

### test/tb_perspective_inverse_mapper.sv
`timescale 1ns / 1ps

module tb_perspective_inverse_mapper;
  import pim_pkg::*;

  localparam int SRC_W = 2048;
  localparam int SRC_H = 2048;
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_SETS = 12;
  localparam int PIXELS_PER_SET = 96;
  localparam longint W_UNITY = 64'sd1073741824;
  localparam longint Q14_SCALE = 64'sd16384;

  typedef enum int {
    SET_NEAR_IDENTITY,
    SET_WIDE_PERSPECTIVE,
    SET_ZERO_COLUMN,
    SET_RAW
  } coef_set_e;

  class mapping_scoreboard;
    typedef struct {
      logic [DIM_W-1:0] dx;
      logic [DIM_W-1:0] dy;
      logic [DIM_W-1:0] sx;
      logic [DIM_W-1:0] sy;
      logic             in_img;
      bit               zero_den;
    } src_point_t;

    logic signed [COEF_W-1:0] coef [NUM_COEF];
    src_point_t pending_q[$];
    int errors;
    int mapped;
    int inside_cnt;
    int zero_den_cnt;

    function new();
      errors = 0;
      mapped = 0;
      inside_cnt = 0;
      zero_den_cnt = 0;
      foreach (coef[i]) coef[i] = '0;
      coef[REG_XX] = ONE_Q16;
      coef[REG_YY] = ONE_Q16;
    endfunction

    function void load_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
      if (idx < NUM_COEF) coef[idx[COEF_IDX_W-1:0]] = data;
    endfunction

    function src_point_t project(logic [DIM_W-1:0] x, logic [DIM_W-1:0] y);
      longint px, py, nx, ny, w, qx, qy;
      src_point_t p;
      px = longint'(x);
      py = longint'(y);
      nx = longint'(coef[REG_XX]) * px + longint'(coef[REG_XY]) * py + longint'(coef[REG_XC]);
      ny = longint'(coef[REG_YX]) * px + longint'(coef[REG_YY]) * py + longint'(coef[REG_YC]);
      w  = longint'(coef[REG_WX]) * px + longint'(coef[REG_WY]) * py + W_UNITY;
      p.dx = x;
      p.dy = y;
      p.sx = '0;
      p.sy = '0;
      p.in_img = 1'b0;
      p.zero_den = (w == 0);
      if (w != 0) begin
        qx = (nx * Q14_SCALE) / w;
        qy = (ny * Q14_SCALE) / w;
        if (qx >= 0 && qx < SRC_W && qy >= 0 && qy < SRC_H) begin
          p.in_img = 1'b1;
          p.sx = DIM_W'(qx);
          p.sy = DIM_W'(qy);
        end
      end
      return p;
    endfunction

    function void note_pixel(logic [DIM_W-1:0] x, logic [DIM_W-1:0] y);
      src_point_t p;
      p = project(x, y);
      pending_q.push_back(p);
      mapped++;
      if (p.in_img) inside_cnt++;
      if (p.zero_den) zero_den_cnt++;
    endfunction

    task report(string msg);
      $display("%0t ns: MISMATCH %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [DIM_W-1:0] sx, logic [DIM_W-1:0] sy, logic in_img);
      src_point_t p;
      if (pending_q.size() == 0) begin
        report($sformatf("result beat (%0d,%0d,%0d) with no pixel outstanding",
                         sx, sy, in_img));
        return;
      end
      p = pending_q.pop_front();
      if (sx !== p.sx)
        report($sformatf("pixel (%0d,%0d) src_x %0d, expected %0d", p.dx, p.dy, sx, p.sx));
      if (sy !== p.sy)
        report($sformatf("pixel (%0d,%0d) src_y %0d, expected %0d", p.dx, p.dy, sy, p.sy));
      if (in_img !== p.in_img)
        report($sformatf("pixel (%0d,%0d) inside_res %0b, expected %0b",
                         p.dx, p.dy, in_img, p.in_img));
    endtask

    function int outstanding();
      return pending_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   calm = 1'b0;
  int   beats_idle = 0;
  int   sets_loaded = 1;

  pim_dst_if dst_ch ();
  pim_src_if src_ch ();
  pim_cfg_if cfg_ch ();

  mapping_scoreboard board = new();

  perspective_inverse_mapper #(
    .SRC_WIDTH (SRC_W),
    .SRC_HEIGHT(SRC_H)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .dst(dst_ch),
    .src(src_ch),
    .cfg(cfg_ch)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int spread(int half);
    return int'($urandom_range(0, 2 * half)) - half;
  endfunction

  function automatic coef_arr_t draw_coefs(coef_set_e kind, int zero_col);
    coef_arr_t c;
    c = '0;
    case (kind)
      SET_NEAR_IDENTITY: begin
        c[REG_XX] = COEF_W'(65536 + spread(16384));
        c[REG_XY] = COEF_W'(spread(16384));
        c[REG_XC] = COEF_W'(spread(1 << 26));
        c[REG_YX] = COEF_W'(spread(16384));
        c[REG_YY] = COEF_W'(65536 + spread(16384));
        c[REG_YC] = COEF_W'(spread(1 << 26));
        c[REG_WX] = COEF_W'(spread(1 << 17));
        c[REG_WY] = COEF_W'(spread(1 << 17));
      end
      SET_WIDE_PERSPECTIVE: begin
        c[REG_XX] = COEF_W'(spread(1 << 17));
        c[REG_XY] = COEF_W'(spread(1 << 17));
        c[REG_XC] = COEF_W'(spread(1 << 28));
        c[REG_YX] = COEF_W'(spread(1 << 17));
        c[REG_YY] = COEF_W'(spread(1 << 17));
        c[REG_YC] = COEF_W'(spread(1 << 28));
        c[REG_WX] = COEF_W'(spread(1 << 19));
        c[REG_WY] = COEF_W'(spread(1 << 19));
      end
      SET_ZERO_COLUMN: begin
        // The denominator vanishes on the whole column x = 2**zero_col.
        c[REG_XX] = COEF_W'(65536 + spread(8192));
        c[REG_XY] = COEF_W'(spread(8192));
        c[REG_XC] = COEF_W'(spread(1 << 24));
        c[REG_YX] = COEF_W'(spread(8192));
        c[REG_YY] = COEF_W'(65536 + spread(8192));
        c[REG_YC] = COEF_W'(spread(1 << 24));
        c[REG_WX] = COEF_W'(-(1 << (30 - zero_col)));
        c[REG_WY] = '0;
      end
      default: begin
        for (int i = 0; i < NUM_COEF; i++) c[i] = $urandom();
      end
    endcase
    return c;
  endfunction

  task automatic send_pixel(input logic [DIM_W-1:0] x, input logic [DIM_W-1:0] y);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      dst_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    dst_ch.valid <= 1'b1;
    dst_ch.dst_x <= x;
    dst_ch.dst_y <= y;
    do @(posedge clk); while (!dst_ch.ready);
  endtask

  task automatic drain();
    dst_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic program_coefs(input coef_arr_t words);
    for (int i = 0; i < NUM_COEF; i++) write_reg(CFG_IDX_W'(i), words[i]);
    // Indexes past the last coefficient must leave every coefficient alone.
    if ($urandom_range(0, 1) == 1)
      write_reg(CFG_IDX_W'(NUM_COEF + $urandom_range(0, (1 << CFG_IDX_W) - NUM_COEF - 1)),
                $urandom());
    cfg_ch.valid <= 1'b0;
    sets_loaded++;
  endtask

  initial begin
    int gap;
    src_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        src_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      src_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      beats_idle = 0;
    end else begin
      if (dst_ch.valid && dst_ch.ready) board.note_pixel(dst_ch.dst_x, dst_ch.dst_y);
      if (src_ch.valid && src_ch.ready)
        board.check_result(src_ch.src_x, src_ch.src_y, src_ch.inside_res);
      if (cfg_ch.valid && cfg_ch.ready) board.load_coef(cfg_ch.index, cfg_ch.data);
      if ((dst_ch.valid && dst_ch.ready) || (src_ch.valid && src_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        beats_idle = 0;
      end else begin
        beats_idle++;
      end
      if (beats_idle >= STALL_LIMIT) begin
        $display("Timeout after %0d cycles without a beat, %0d results outstanding.",
                 beats_idle, board.outstanding());
        $display("tb_perspective_inverse_mapper failed");
        $finish;
      end
    end
  end

  initial begin
    coef_arr_t cs;
    coef_arr_t unity;
    coef_set_e kind;
    logic [DIM_W-1:0] px;
    logic [DIM_W-1:0] py;
    int zero_col;
    int r;

    dst_ch.valid <= 1'b0;
    dst_ch.dst_x <= '0;
    dst_ch.dst_y <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data  <= '0;
    unity = '0;
    unity[REG_XX] = ONE_Q16;
    unity[REG_YY] = ONE_Q16;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset coefficients map each pixel onto itself; pixels at 2048 and past lie outside.
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(2047, 2047);
    send_pixel(2048, 100);
    send_pixel(100, 2048);
    send_pixel(4095, 0);
    send_pixel(0, 4095);
    send_pixel(2047, 0);
    send_pixel(1365, 2730);
    drain();

    // A denominator weight of minus one puts a zero denominator at x = 1.
    cs = unity;
    cs[REG_WX] = 32'hC000_0000;
    program_coefs(cs);
    send_pixel(1, 0);
    send_pixel(2, 5);
    send_pixel(0, 7);
    drain();

    // A half-pixel x offset and a whole-pixel y offset give quotients just below zero and right at the bound.
    cs = unity;
    cs[REG_XC] = COEF_W'(-32768);
    cs[REG_YC] = COEF_W'(-65536);
    program_coefs(cs);
    send_pixel(0, 0);
    send_pixel(0, 1);
    send_pixel(5, 2048);
    send_pixel(5, 2049);
    drain();

    cs = {NUM_COEF{32'h7FFF_FFFF}};
    program_coefs(cs);
    send_pixel(4095, 4095);
    send_pixel(0, 0);
    send_pixel(1, 1);
    drain();

    cs = {NUM_COEF{32'h8000_0000}};
    program_coefs(cs);
    send_pixel(4095, 4095);
    send_pixel(0, 0);
    drain();

    for (int k = 0; k < RANDOM_SETS; k++) begin
      kind = coef_set_e'(k % 4);
      calm = (k % 3 == 1);
      zero_col = $urandom_range(0, DIM_W - 1);
      program_coefs(draw_coefs(kind, zero_col));
      repeat (PIXELS_PER_SET) begin
        r = $urandom_range(0, 9);
        px = DIM_W'($urandom());
        py = DIM_W'($urandom());
        if (kind == SET_ZERO_COLUMN && r < 3) begin
          px = DIM_W'(1 << zero_col);
        end else if (r == 9) begin
          case ($urandom_range(0, 3))
            0: px = '0;
            1: px = '1;
            2: py = '0;
            default: py = '1;
          endcase
        end
        send_pixel(px, py);
      end
      drain();
    end
    calm = 1'b0;

    repeat (30) @(posedge clk);
    $display("Mapped %0d pixels under %0d coefficient sets: %0d inside, %0d zero denominators.",
             board.mapped, sets_loaded, board.inside_cnt, board.zero_den_cnt);
    $display("Mismatches: %0d, results still outstanding: %0d.",
             board.errors, board.outstanding());
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("tb_perspective_inverse_mapper passed");
    end else begin
      $display("tb_perspective_inverse_mapper failed");
    end
    $finish;
  end

endmodule

### perspective_inverse_mapper.f
rtl/pim_pkg.sv
rtl/pim_dst_if.sv
rtl/pim_src_if.sv
rtl/pim_cfg_if.sv
rtl/pim_cfg.sv
rtl/pim_front.sv
rtl/pim_div.sv
rtl/perspective_inverse_mapper.sv
test/tb_perspective_inverse_mapper.sv
